[design/gos_pkg.sv]
// Shared types and constants of the greedy overlap suppression block.
package gos_pkg;

    localparam int MAX_SEGMENTS = 32;
    localparam int COORD_BITS   = 12;
    localparam int IDX_BITS     = $clog2(MAX_SEGMENTS);
    localparam int CNT_BITS     = $clog2(MAX_SEGMENTS + 1);
    localparam int AREA_BITS    = 2 * COORD_BITS;
    localparam int EDGE_BITS    = COORD_BITS + 1;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;
        logic [1:0]            method;
        logic [15:0]           score;
        logic [7:0]            dyn_range;
    } seg_t;

    localparam int SEG_BITS = $bits(seg_t);

    function automatic logic seg_overlaps(seg_t a, seg_t b);
        logic [EDGE_BITS-1:0] l;
        logic [EDGE_BITS-1:0] t;
        logic [EDGE_BITS-1:0] ra;
        logic [EDGE_BITS-1:0] rb;
        logic [EDGE_BITS-1:0] ba;
        logic [EDGE_BITS-1:0] bb;
        logic [EDGE_BITS-1:0] r;
        logic [EDGE_BITS-1:0] bt;
        l  = (a.x > b.x) ? {1'b0, a.x} : {1'b0, b.x};
        t  = (a.y > b.y) ? {1'b0, a.y} : {1'b0, b.y};
        ra = {1'b0, a.x} + {1'b0, a.w};
        rb = {1'b0, b.x} + {1'b0, b.w};
        ba = {1'b0, a.y} + {1'b0, a.h};
        bb = {1'b0, b.y} + {1'b0, b.h};
        r  = (ra < rb) ? ra : rb;
        bt = (ba < bb) ? ba : bb;
        return (r > l) && (bt > t);
    endfunction

    function automatic logic seg_better(seg_t n, seg_t o);
        if (n.method == o.method)
        begin
            return n.score > o.score;
        end
        return n.dyn_range > o.dyn_range;
    endfunction

endpackage

[design/gos_if.sv]
// Valid/ready channel interfaces for segments and kept results.
interface gos_seg_if
    import gos_pkg::*;
();
    logic valid;
    logic ready;
    logic [COORD_BITS-1:0] rect_x;
    logic [COORD_BITS-1:0] rect_y;
    logic [COORD_BITS-1:0] rect_w;
    logic [COORD_BITS-1:0] rect_h;
    logic [1:0]            method;
    logic [15:0]           score;
    logic [7:0]            dyn_range;
    logic                  last;
    modport source (output valid, rect_x, rect_y, rect_w, rect_h, method, score,
                    dyn_range, last, input ready);
    modport sink (input valid, rect_x, rect_y, rect_w, rect_h, method, score,
                  dyn_range, last, output ready);
endinterface

interface gos_res_if
    import gos_pkg::*;
();
    logic valid;
    logic ready;
    logic [COORD_BITS-1:0] out_x;
    logic [COORD_BITS-1:0] out_y;
    logic [COORD_BITS-1:0] out_w;
    logic [COORD_BITS-1:0] out_h;
    logic [1:0]            out_method;
    logic [15:0]           out_score;
    logic [7:0]            out_dyn_range;
    logic                  overflow;
    logic                  out_last;
    modport source (output valid, out_x, out_y, out_w, out_h, out_method, out_score,
                    out_dyn_range, overflow, out_last, input ready);
    modport sink (input valid, out_x, out_y, out_w, out_h, out_method, out_score,
                  out_dyn_range, overflow, out_last, output ready);
endinterface

[design/greedy_overlap_suppression.sv]
// Top level of the greedy overlap suppression block.
//
// Segments arrive on the seg channel, one per transfer, and a set is closed
// by a transfer with last set. Each segment is inserted into an area-sorted
// store held in a RAM; the insertion shifts one entry per cycle, and the next
// segment is accepted only after the insertion ends. A store of 32 entries
// drops further segments and raises overflow on every result of the set.
// After the last segment the suppression pass walks the unique table in a
// second RAM for each stored segment, bounded by the 32 by 32 compare loop.
// Kept segments then leave on the res channel in table order, the final one
// with out_last. A result waits in the output register while the receiver
// stalls, and the block holds its emit pass until it is taken. No segment is
// accepted between the last of a set and the transfer of its final result.
// Reset empties the store and the table and clears the overflow flag.
module greedy_overlap_suppression
    import gos_pkg::*;
(
    input logic clk,
    input logic rst_n,
    gos_seg_if.sink   seg,
    gos_res_if.source res
);
    gos_core u_core (.clk(clk), .rst_n(rst_n), .seg(seg), .res(res));
endmodule

[design/gos_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module gos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[design/gos_core.sv]
// Sequencer: sorted insert into the segment store, suppression pass, emit.
module gos_core
    import gos_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    gos_seg_if.sink   seg,
    gos_res_if.source res
);
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SHIFT  = 3'd1;
    localparam logic [2:0] ST_SREAD  = 3'd2;
    localparam logic [2:0] ST_UREAD  = 3'd3;
    localparam logic [2:0] ST_UCMP   = 3'd4;
    localparam logic [2:0] ST_EREAD  = 3'd5;
    localparam logic [2:0] ST_EOUT   = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [CNT_BITS-1:0] in_cnt_reg, in_cnt_next;
    logic [CNT_BITS-1:0] u_cnt_reg, u_cnt_next;
    logic [CNT_BITS-1:0] pos_reg, pos_next;
    logic [CNT_BITS-1:0] i_reg, i_next;
    logic [CNT_BITS-1:0] j_reg, j_next;
    logic                ovf_reg, ovf_next;
    logic                last_reg, last_next;
    seg_t                new_reg, new_next;
    seg_t                cur_reg, cur_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_last_reg, out_last_next;
    seg_t                out_reg, out_next;

    logic                s_we, u_we;
    logic [IDX_BITS-1:0] s_waddr, s_raddr, u_waddr, u_raddr;
    seg_t                s_wdata, u_wdata, s_rdata, u_rdata;
    logic [AREA_BITS-1:0] new_area, rd_area;

    gos_ram #(.WIDTH(SEG_BITS), .DEPTH(MAX_SEGMENTS)) u_store (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata));

    gos_ram #(.WIDTH(SEG_BITS), .DEPTH(MAX_SEGMENTS)) u_uniq (
        .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
        .raddr(u_raddr), .rdata(u_rdata));

    assign new_area = new_reg.w * new_reg.h;
    assign rd_area  = s_rdata.w * s_rdata.h;

    assign seg.ready = (state_reg == ST_IDLE);
    assign res.valid         = out_valid_reg;
    assign res.out_x         = out_reg.x;
    assign res.out_y         = out_reg.y;
    assign res.out_w         = out_reg.w;
    assign res.out_h         = out_reg.h;
    assign res.out_method    = out_reg.method;
    assign res.out_score     = out_reg.score;
    assign res.out_dyn_range = out_reg.dyn_range;
    assign res.overflow      = ovf_reg;
    assign res.out_last      = out_last_reg;

    always_comb
    begin
        state_next     = state_reg;
        in_cnt_next    = in_cnt_reg;
        u_cnt_next     = u_cnt_reg;
        pos_next       = pos_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        ovf_next       = ovf_reg;
        last_next      = last_reg;
        new_next       = new_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        out_next       = out_reg;
        s_we    = 1'b0;
        s_waddr = pos_reg[IDX_BITS-1:0];
        s_wdata = new_reg;
        s_raddr = pos_reg[IDX_BITS-1:0];
        u_we    = 1'b0;
        u_waddr = j_reg[IDX_BITS-1:0];
        u_wdata = cur_reg;
        u_raddr = j_reg[IDX_BITS-1:0];

        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (seg.valid)
                begin
                    new_next = '{x: seg.rect_x, y: seg.rect_y, w: seg.rect_w,
                                 h: seg.rect_h, method: seg.method,
                                 score: seg.score, dyn_range: seg.dyn_range};
                    last_next = seg.last;
                    if (in_cnt_reg < CNT_BITS'(MAX_SEGMENTS))
                    begin
                        pos_next   = in_cnt_reg;
                        state_next = ST_SHIFT;
                        s_raddr    = IDX_BITS'(in_cnt_reg - 1'b1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                        if (seg.last)
                        begin
                            i_next = '0; j_next = '0; u_cnt_next = '0;
                            state_next = ST_SREAD;
                        end
                    end
                end
            end
            ST_SHIFT:
            begin
                // Entry pos-1 is on the read port; insertion walks toward the head.
                if (pos_reg != '0 && rd_area < new_area)
                begin
                    s_we    = 1'b1;
                    s_wdata = s_rdata;
                    pos_next = pos_reg - 1'b1;
                    s_raddr  = IDX_BITS'(pos_reg - 2'd2);
                end
                else
                begin
                    s_we = 1'b1;
                    in_cnt_next = in_cnt_reg + 1'b1;
                    if (last_reg)
                    begin
                        i_next = '0; j_next = '0; u_cnt_next = '0;
                        state_next = ST_SREAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SREAD:
            begin
                if (i_reg == in_cnt_reg)
                begin
                    j_next = '0;
                    state_next = ST_EREAD;
                end
                else
                begin
                    s_raddr = i_reg[IDX_BITS-1:0];
                    state_next = ST_UREAD;
                end
            end
            ST_UREAD:
            begin
                cur_next = s_rdata;
                j_next = '0;
                if (u_cnt_reg == '0)
                begin
                    u_we = 1'b1; u_waddr = '0; u_wdata = s_rdata;
                    u_cnt_next = CNT_BITS'(1);
                    i_next = i_reg + 1'b1;
                    state_next = ST_SREAD;
                end
                else
                begin
                    u_raddr = '0;
                    state_next = ST_UCMP;
                end
            end
            ST_UCMP:
            begin
                if (seg_overlaps(cur_reg, u_rdata))
                begin
                    u_we = seg_better(cur_reg, u_rdata);
                    i_next = i_reg + 1'b1;
                    state_next = ST_SREAD;
                end
                else if (j_reg + 1'b1 == u_cnt_reg)
                begin
                    u_we = 1'b1;
                    u_waddr = u_cnt_reg[IDX_BITS-1:0];
                    u_cnt_next = u_cnt_reg + 1'b1;
                    i_next = i_reg + 1'b1;
                    state_next = ST_SREAD;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                    u_raddr = IDX_BITS'(j_reg + 1'b1);
                end
            end
            ST_EREAD:
            begin
                if (j_reg == u_cnt_reg)
                begin
                    if (!out_valid_next)
                    begin
                        in_cnt_next = '0; u_cnt_next = '0; ovf_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    u_raddr = j_reg[IDX_BITS-1:0];
                    state_next = ST_EOUT;
                end
            end
            ST_EOUT:
            begin
                if (!out_valid_next)
                begin
                    out_valid_next = 1'b1;
                    out_next = u_rdata;
                    out_last_next = (j_reg + 1'b1 == u_cnt_reg);
                    j_next = j_reg + 1'b1;
                    state_next = ST_EREAD;
                end
                else
                begin
                    u_raddr = j_reg[IDX_BITS-1:0];
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_cnt_reg    <= '0;
            u_cnt_reg     <= '0;
            pos_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            ovf_reg       <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_cnt_reg    <= in_cnt_next;
            u_cnt_reg     <= u_cnt_next;
            pos_reg       <= pos_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            ovf_reg       <= ovf_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_reg <= new_next;
        cur_reg <= cur_next;
        out_reg <= out_next;
    end
endmodule

[design/gos_checker.sv]
// Port checker for the greedy overlap suppression block, with its bind.
module gos_checker
    import gos_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic seg_valid,
    input logic seg_ready,
    input logic res_valid,
    input logic res_ready,
    input logic res_last
);
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_seg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid && !seg_ready |=> seg_valid)
        else $error("segment withdrawn while stalled");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !seg_ready)
        else $error("segment accepted during emit");

    a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && res_last |=> !res_valid)
        else $error("result after final result");
endmodule

bind greedy_overlap_suppression gos_checker u_gos_checker (
    .clk(clk), .rst_n(rst_n), .seg_valid(seg.valid), .seg_ready(seg.ready),
    .res_valid(res.valid), .res_ready(res.ready), .res_last(res.out_last));
